// ===== hw/rtl/suffix_automaton_builder_defines.svh =====
// Assertion macros for the suffix automaton builder
`ifndef SUFFIX_AUTOMATON_BUILDER_DEFINES_SVH
`define SUFFIX_AUTOMATON_BUILDER_DEFINES_SVH
// assert that a condition implies a consequent in the same cycle
`define SAB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// assert that a condition implies a consequent in the next cycle
`define SAB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== hw/rtl/sab_pkg.sv =====
// Package for the suffix automaton builder: constants and sequencer states
`default_nettype none
package sab_pkg;
    localparam int MAX_LEN_DEF  = 1024;
    localparam int ALPHABET_DEF = 26;
    localparam int SYM_W        = 5;
    localparam int ST_W         = 11;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LEN,
        S_WALK_RD,
        S_WALK_EV,
        S_Q_RD,
        S_Q_EV,
        S_CP_RD,
        S_CP_WR,
        S_RD_RD,
        S_RD_EV,
        S_OUT
    } t_state;
endpackage
`default_nettype wire

// ===== hw/rtl/sab_mem.sv =====
// Single-port-write, registered-read memory for the builder tables
`default_nettype none
module sab_mem #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11,
    parameter int DW    = 11
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/suffix_automaton_builder.sv =====
// Top level: online suffix automaton builder with a small sequencer
// Steps: a length write, then a suffix walk that ends past the root or stops on a state with a
// transition; a clone copies every transition of that state, then redirects along the walk.
// A refused word goes straight to the output. Throughput: one word at a time; stall is high while busy.
// A new word is taken while the previous result waits in the output register.
// Reset: a clearing pass over every state and symbol zeroes the tables; no word meanwhile.
`default_nettype none
`include "suffix_automaton_builder_defines.svh"
module suffix_automaton_builder #(
    parameter int MAX_LEN  = sab_pkg::MAX_LEN_DEF,
    parameter int ALPHABET = sab_pkg::ALPHABET_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic [sab_pkg::SYM_W-1:0] i_symbol,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic [sab_pkg::ST_W-1:0]      o_new_state,
    output logic [sab_pkg::ST_W-1:0]      o_state_count,
    output logic                          o_cloned,
    output logic [sab_pkg::ST_W-1:0]      o_clone_state,
    output logic                          o_overflow
);
    import sab_pkg::*;

    localparam int NSTATES = 2 * MAX_LEN + 2;
    localparam int SW      = $clog2(NSTATES);
    localparam int CW      = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int TDEPTH  = NSTATES * ALPHABET;
    localparam int TW      = $clog2(TDEPTH);
    localparam int LW      = $clog2(MAX_LEN + 1);

    t_state r_st, n_st;
    logic [SW-1:0] r_cur, n_cur, r_p, n_p, r_q, n_q, r_clone, n_clone;
    logic [SW-1:0] r_last, n_last, r_high, n_high;
    logic [LW-1:0] r_taken, n_taken;
    logic [CW-1:0] r_c, n_c, r_k, n_k;
    logic [SW-1:0] r_clr, n_clr;
    logic          r_made, n_made;
    logic [SW-1:0] r_lenp, n_lenp;
    logic          r_ov, n_ov, r_ok, n_ok;
    logic          r_ovalid, n_ovalid;
    logic [ST_W-1:0] r_o_new, n_o_new, r_o_cnt, n_o_cnt, r_o_cl, n_o_cl;
    logic r_o_cld, n_o_cld, r_o_ovf, n_o_ovf;

    // table port
    logic          t_we;
    logic [TW-1:0] t_wa, t_ra;
    logic [SW-1:0] t_wd, t_rd;
    // link and length ports
    logic          l_we, g_we;
    logic [SW-1:0] l_wa, l_wd, l_ra, l_rd, g_wa, g_wd, g_ra, g_rd;

    sab_mem #(.DEPTH(TDEPTH), .AW(TW), .DW(SW)) u_trans (
        .i_clk(i_clk), .i_we(t_we), .i_waddr(t_wa), .i_wdata(t_wd),
        .i_raddr(t_ra), .o_rdata(t_rd)
    );
    sab_mem #(.DEPTH(NSTATES), .AW(SW), .DW(SW)) u_link (
        .i_clk(i_clk), .i_we(l_we), .i_waddr(l_wa), .i_wdata(l_wd),
        .i_raddr(l_ra), .o_rdata(l_rd)
    );
    sab_mem #(.DEPTH(NSTATES), .AW(SW), .DW(SW)) u_len (
        .i_clk(i_clk), .i_we(g_we), .i_waddr(g_wa), .i_wdata(g_wd),
        .i_raddr(g_ra), .o_rdata(g_rd)
    );

    function automatic logic [TW-1:0] taddr(input logic [SW-1:0] s, input logic [CW-1:0] c);
        logic [TW:0] a;
        a = TW'(s) * TW'(ALPHABET) + TW'(c);
        return a[TW-1:0];
    endfunction

    function automatic logic [SW-1:0] wrap(input logic [SW:0] s);
        return (s >= (SW+1)'(NSTATES)) ? '0 : s[SW-1:0];
    endfunction

    logic in_acc, out_acc;
    assign in_acc  = i_valid && !o_stall;
    assign out_acc = r_ovalid && !i_stall;
    assign o_stall = (r_st != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLEAR;
            r_last <= SW'(1);
            r_high <= SW'(1);
            r_taken <= '0;
            r_clr <= '0;
            r_k <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            r_last <= n_last;
            r_high <= n_high;
            r_taken <= n_taken;
            r_clr <= n_clr;
            r_k <= n_k;
            r_ovalid <= n_ovalid;
        end
        r_cur <= n_cur; r_p <= n_p; r_q <= n_q; r_clone <= n_clone;
        r_c <= n_c; r_made <= n_made; r_lenp <= n_lenp; r_ov <= n_ov; r_ok <= n_ok;
        r_o_new <= n_o_new; r_o_cnt <= n_o_cnt; r_o_cl <= n_o_cl;
        r_o_cld <= n_o_cld; r_o_ovf <= n_o_ovf;
    end

    always_comb begin
        n_st = r_st; n_cur = r_cur; n_p = r_p; n_q = r_q; n_clone = r_clone;
        n_last = r_last; n_high = r_high; n_taken = r_taken; n_c = r_c; n_k = r_k;
        n_clr = r_clr; n_made = r_made; n_lenp = r_lenp; n_ov = r_ov; n_ok = r_ok;
        n_ovalid = r_ovalid && i_stall;
        n_o_new = r_o_new; n_o_cnt = r_o_cnt; n_o_cl = r_o_cl;
        n_o_cld = r_o_cld; n_o_ovf = r_o_ovf;
        t_we = 1'b0; t_wa = taddr(r_clr, r_k); t_wd = '0; t_ra = taddr(r_p, r_c);
        l_we = 1'b0; l_wa = r_clr; l_wd = '0; l_ra = r_p;
        g_we = 1'b0; g_wa = r_clr; g_wd = '0; g_ra = r_last;
        case (r_st)
            S_CLEAR: begin
                t_we = 1'b1;
                l_we = (r_k == '0);
                g_we = (r_k == '0);
                if (r_k == CW'(ALPHABET - 1)) begin
                    n_k = '0;
                    if (r_clr == SW'(NSTATES - 1)) begin
                        n_st = S_IDLE;
                    end else begin
                        n_clr = r_clr + SW'(1);
                    end
                end else begin
                    n_k = r_k + CW'(1);
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_c = i_symbol[CW-1:0];
                    n_made = 1'b0;
                    n_clone = '0;
                    n_ov = (r_taken >= LW'(MAX_LEN));
                    n_ok = (32'(i_symbol) < ALPHABET);
                    n_cur = wrap({1'b0, r_high} + (SW+1)'(1));
                    n_p = r_last;
                    n_st = S_LEN;
                end
            end
            S_LEN: begin
                if (r_ov || !r_ok) begin
                    n_st = S_OUT;
                end else begin
                    g_we = 1'b1; g_wa = r_cur; g_wd = g_rd + SW'(1);
                    n_high = r_cur;
                    n_st = S_WALK_RD;
                end
            end
            S_WALK_RD: begin
                if (r_p == '0) begin
                    l_we = 1'b1; l_wa = r_cur; l_wd = SW'(1);
                    n_st = S_OUT;
                end else begin
                    t_ra = taddr(r_p, r_c); l_ra = r_p; g_ra = r_p;
                    n_st = S_WALK_EV;
                end
            end
            S_WALK_EV: begin
                if (t_rd == '0) begin
                    t_we = 1'b1; t_wa = taddr(r_p, r_c); t_wd = r_cur;
                    n_p = wrap({1'b0, l_rd});
                    n_st = S_WALK_RD;
                end else begin
                    n_q = wrap({1'b0, t_rd});
                    n_lenp = g_rd;
                    n_st = S_Q_RD;
                end
            end
            S_Q_RD: begin
                g_ra = r_q; l_ra = r_q;
                n_st = S_Q_EV;
            end
            S_Q_EV: begin
                if (g_rd == r_lenp + SW'(1)) begin
                    l_we = 1'b1; l_wa = r_cur; l_wd = r_q;
                    n_st = S_OUT;
                end else begin
                    n_clone = wrap({1'b0, r_high} + (SW+1)'(1));
                    n_high = n_clone;
                    n_made = 1'b1;
                    g_we = 1'b1; g_wa = n_clone; g_wd = r_lenp + SW'(1);
                    l_we = 1'b1; l_wa = n_clone; l_wd = l_rd;
                    n_k = '0;
                    n_st = S_CP_RD;
                end
            end
            S_CP_RD: begin
                t_ra = taddr(r_q, r_k);
                n_st = S_CP_WR;
            end
            S_CP_WR: begin
                t_we = 1'b1; t_wa = taddr(r_clone, r_k); t_wd = t_rd;
                if (r_k == CW'(ALPHABET - 1)) begin
                    n_k = '0;
                    l_we = 1'b1; l_wa = r_q; l_wd = r_clone;
                    n_st = S_RD_RD;
                end else begin
                    n_k = r_k + CW'(1);
                    n_st = S_CP_RD;
                end
            end
            S_RD_RD: begin
                if (r_p == '0) begin
                    l_we = 1'b1; l_wa = r_cur; l_wd = r_clone;
                    n_st = S_OUT;
                end else begin
                    t_ra = taddr(r_p, r_c); l_ra = r_p;
                    n_st = S_RD_EV;
                end
            end
            S_RD_EV: begin
                if (t_rd == r_q) begin
                    t_we = 1'b1; t_wa = taddr(r_p, r_c); t_wd = r_clone;
                    n_p = wrap({1'b0, l_rd});
                    n_st = S_RD_RD;
                end else begin
                    l_we = 1'b1; l_wa = r_cur; l_wd = r_clone;
                    n_st = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1;
                    n_o_cnt = ST_W'(r_high);
                    n_o_ovf = r_ov;
                    if (r_ov || !r_ok) begin
                        n_o_new = '0; n_o_cld = 1'b0; n_o_cl = '0;
                    end else begin
                        n_o_new = ST_W'(r_cur);
                        n_o_cld = r_made;
                        n_o_cl = ST_W'(r_clone);
                        n_last = r_cur;
                        n_taken = r_taken + LW'(1);
                    end
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    assign o_valid       = r_ovalid;
    assign o_new_state   = r_o_new;
    assign o_state_count = r_o_cnt;
    assign o_cloned      = r_o_cld;
    assign o_clone_state = r_o_cl;
    assign o_overflow    = r_o_ovf;

    `SAB_ASSERT_IMP(a_ov_no_new, i_clk, i_rst_n, r_ovalid && r_o_ovf, r_o_new == '0 && !r_o_cld)
    `SAB_ASSERT_IMP(a_cl_zero, i_clk, i_rst_n, r_ovalid && !r_o_cld, r_o_cl == '0)
    `SAB_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_acc == 1'b0 && r_ovalid, r_ovalid)
    `SAB_ASSERT_IMP(a_no_take_busy, i_clk, i_rst_n, r_st != S_IDLE, o_stall)
endmodule
`default_nettype wire

// ===== verif/tb_suffix_automaton_builder.sv =====
// Testbench for suffix_automaton_builder: directed and random symbol streams checked against an automaton model
`timescale 1ns / 1ps
module tb_suffix_automaton_builder;
    import sab_pkg::*;

    localparam int MAXLEN    = MAX_LEN_DEF;
    localparam int ALPH      = ALPHABET_DEF;
    localparam int NST       = 2 * MAXLEN + 2;
    localparam int N_RANDOM  = 1200;
    localparam int IDLE_LIMIT = 200000;

    typedef struct {
        logic [ST_W-1:0] new_state;
        logic [ST_W-1:0] state_count;
        logic            cloned;
        logic [ST_W-1:0] clone_state;
        logic            overflow;
    } t_step_result;

    class automaton_scoreboard;
        int unsigned trans[NST][ALPH];
        int unsigned link[NST];
        int unsigned len[NST];
        int unsigned last_st;
        int unsigned high_st;
        int unsigned taken;
        t_step_result pending_results[$];
        int errors;

        function new();
            foreach (trans[s, c]) trans[s][c] = 0;
            foreach (link[s]) begin
                link[s] = 0;
                len[s] = 0;
            end
            last_st = 1;
            high_st = 1;
            taken = 0;
            errors = 0;
        endfunction

        function int unsigned clip(int unsigned s);
            return s < NST ? s : 0;
        endfunction

        function void note_symbol(logic [SYM_W-1:0] sym);
            t_step_result r;
            int unsigned c, cur, p, q, cl;
            r.new_state = 0;
            r.state_count = high_st[ST_W-1:0];
            r.cloned = 0;
            r.clone_state = 0;
            r.overflow = 0;
            cl = 0;
            if (taken >= MAXLEN) begin
                r.overflow = 1;
            end else if (sym < ALPH) begin
                c = sym;
                cur = clip(high_st + 1);
                high_st = cur;
                len[cur] = len[clip(last_st)] + 1;
                p = clip(last_st);
                while (p != 0 && trans[p][c] == 0) begin
                    trans[p][c] = cur;
                    p = clip(link[p]);
                end
                if (p == 0) begin
                    link[cur] = 1;
                end else begin
                    q = clip(trans[p][c]);
                    if (len[q] == len[p] + 1) begin
                        link[cur] = q;
                    end else begin
                        cl = clip(high_st + 1);
                        high_st = cl;
                        r.cloned = 1;
                        len[cl] = len[p] + 1;
                        for (int k = 0; k < ALPH; k++) trans[cl][k] = trans[q][k];
                        link[cl] = link[q];
                        link[q] = cl;
                        link[cur] = cl;
                        while (p != 0 && trans[p][c] == q) begin
                            trans[p][c] = cl;
                            p = clip(link[p]);
                        end
                    end
                end
                last_st = cur;
                taken++;
                r.new_state = cur[ST_W-1:0];
                r.state_count = high_st[ST_W-1:0];
                r.clone_state = cl[ST_W-1:0];
            end
            pending_results = {pending_results, r};
        endfunction

        function void check_result(t_step_result got);
            t_step_result exp_r;
            if (pending_results.size() == 0) begin
                $error("result word with no expectation waiting");
                errors++;
                return;
            end
            exp_r = pending_results.pop_front();
            if (got.new_state !== exp_r.new_state) begin
                $error("new_state: expected %0d, got %0d", exp_r.new_state, got.new_state);
                errors++;
            end
            if (got.state_count !== exp_r.state_count) begin
                $error("state_count: expected %0d, got %0d", exp_r.state_count,
                       got.state_count);
                errors++;
            end
            if (got.cloned !== exp_r.cloned) begin
                $error("cloned: expected %0d, got %0d", exp_r.cloned, got.cloned);
                errors++;
            end
            if (got.clone_state !== exp_r.clone_state) begin
                $error("clone_state: expected %0d, got %0d", exp_r.clone_state,
                       got.clone_state);
                errors++;
            end
            if (got.overflow !== exp_r.overflow) begin
                $error("overflow: expected %0d, got %0d", exp_r.overflow, got.overflow);
                errors++;
            end
        endfunction
    endclass

    logic            i_clk;
    logic            i_rst_n;
    logic            i_valid;
    logic            o_stall;
    logic [SYM_W-1:0] i_symbol;
    logic            o_valid;
    logic            i_stall;
    logic [ST_W-1:0] o_new_state;
    logic [ST_W-1:0] o_state_count;
    logic            o_cloned;
    logic [ST_W-1:0] o_clone_state;
    logic            o_overflow;

    automaton_scoreboard sb;
    int idle_cycles;
    bit no_gaps;

    suffix_automaton_builder u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_symbol      (i_symbol),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_new_state   (o_new_state),
        .o_state_count (o_state_count),
        .o_cloned      (o_cloned),
        .o_clone_state (o_clone_state),
        .o_overflow    (o_overflow)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_symbol(logic [SYM_W-1:0] sym);
        int gap;
        i_valid <= 1'b1;
        i_symbol <= sym;
        do @(posedge i_clk); while (o_stall);
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.note_symbol(i_symbol);
            if (o_valid && !i_stall)
                sb.check_result('{o_new_state, o_state_count, o_cloned,
                                  o_clone_state, o_overflow});
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // hold stall in bursts: mostly short, a few long, none while gaps are off
    initial begin
        int burst;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            burst = pick_gap();
            if (burst > 0) begin
                i_stall <= 1'b1;
                repeat (burst) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        logic [SYM_W-1:0] directed[22];
        int r;
        directed = '{0, 1, 0, 1, 0, 1, 1, 25, 25, 26, 31, 2, 0, 1, 2,
                     16, 0, 0, 0, 15, 8, 4};
        sb = new();
        idle_cycles = 0;
        no_gaps = 0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_symbol <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[k]) send_symbol(directed[k]);
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 75) send_symbol(SYM_W'($urandom_range(0, 2)));
            else if (r < 90) send_symbol(SYM_W'($urandom_range(0, ALPH - 1)));
            else send_symbol(SYM_W'($urandom_range(ALPH, 31)));
        end
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/sab_pkg.sv
hw/rtl/sab_mem.sv
hw/rtl/suffix_automaton_builder.sv
verif/tb_suffix_automaton_builder.sv
